@@ rtl/core/sh9_pkg.sv @@
// Package: shared types, constants and helpers of the SH9 projection block.
package sh9_pkg;
   localparam int NUM_CH = 3;
   localparam int NUM_BASIS = 9;
   localparam int NUM_ACC = 27;
   localparam logic [31:0] GAIN_RESET = 32'd65536;
   localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [47:0] OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] OUT_NEG_MAG = 48'h8000_0000_0000;

   typedef logic signed [63:0] acc_type;
   typedef logic signed [19:0] basis_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [14:0] sin_weight;
      logic last_pixel;
   } req_type;

   typedef struct packed {
      logic [1:0] channel;
      logic [3:0] coeff_index;
      logic signed [47:0] coeff_value;
      logic last_coeff;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
   } lane_ctl_type;

   // Q1.14 basis constants
   function automatic logic [14:0] basis_const(input logic [3:0] k);
      logic [14:0] r;
      case (k)
         4'd0: r = 15'd4622;
         4'd1, 4'd2, 4'd3: r = 15'd8005;
         4'd4, 4'd5, 4'd6: r = 15'd17900;
         4'd7: r = 15'd5167;
         default: r = 15'd8950;
      endcase
      return r;
   endfunction

   // signed round to Q.14: floor((v + 8192) / 2^14)
   function automatic logic signed [63:0] round_q14(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd8192;
      return t >>> 14;
   endfunction

   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      acc_type s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) s = ACC_MAX;
      else if (a[63] && b[63] && !s[63]) s = ACC_MIN;
      return s;
   endfunction
endpackage

@@ rtl/core/sh9_stream_if.sv @@
// Interface: valid/ready channel carrying one payload struct.
interface sh9_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sh9_basis.sv @@
// Basis stage: nine constant-scaled basis values and weighted RGB, registered over two stages.
module sh9_basis (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  sh9_pkg::req_type in_item,
   output logic out_valid,
   output sh9_pkg::basis_type out_basis [9],
   output logic [16:0] out_rw [3],
   output logic out_last
);
   import sh9_pkg::*;
   logic s1_valid_ff, s1_last_ff, s2_valid_ff, s2_last_ff;
   logic signed [63:0] raw_ff [9];
   logic [16:0] rw_ff [3];
   logic [16:0] rw2_ff [3];
   basis_type b_ff [9];
   logic signed [63:0] raw_in [9];
   logic [16:0] rw_in [3];
   logic signed [63:0] x, y, z;
   logic [15:0] c [3];

   always_comb begin
      x = 64'(in_item.dir_x);
      y = 64'(in_item.dir_y);
      z = 64'(in_item.dir_z);
      raw_in[0] = 64'sd16384;
      raw_in[1] = y;
      raw_in[2] = z;
      raw_in[3] = x;
      raw_in[4] = round_q14(x * y);
      raw_in[5] = round_q14(y * z);
      raw_in[6] = round_q14(x * z);
      raw_in[7] = round_q14(64'sd3 * z * z - (64'sd1 <<< 28));
      raw_in[8] = round_q14(x * x - y * y);
      c[0] = in_item.red;
      c[1] = in_item.green;
      c[2] = in_item.blue;
      // weights above 1.0 give up to 17 bits
      for (int i = 0; i < 3; i++)
         rw_in[i] = 17'(({15'd0, c[i]} * {16'd0, in_item.sin_weight} + 31'd8192) >> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_last_ff <= in_item.last_pixel;
      s2_last_ff <= s1_last_ff;
      raw_ff <= raw_in;
      rw_ff <= rw_in;
      rw2_ff <= rw_ff;
      for (int k = 0; k < 9; k++)
         b_ff[k] <= basis_type'(round_q14(raw_ff[k] *
                    $signed({49'd0, basis_const(4'(k))})));
   end

   assign out_valid = s2_valid_ff;
   assign out_last = s2_last_ff;
   assign out_basis = b_ff;
   assign out_rw = rw2_ff;
endmodule

@@ rtl/core/sh9_lane.sv @@
// Accumulator lane: one color channel, nine saturating accumulators.
module sh9_lane (
   input  logic clock,
   input  logic reset,
   input  logic acc_en,
   input  logic clear,
   input  logic [16:0] rw,
   input  sh9_pkg::basis_type basis [9],
   output sh9_pkg::acc_type acc [9]
);
   import sh9_pkg::*;
   acc_type acc_ff [9];
   acc_type prod_ff [9];
   logic en_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++)
         prod_ff[k] <= 64'($signed({1'b0, rw}) * basis[k]);
      if (reset) begin
         en_ff <= 1'b0;
         for (int k = 0; k < 9; k++) acc_ff[k] <= '0;
      end else begin
         en_ff <= acc_en;
         for (int k = 0; k < 9; k++) begin
            if (clear) acc_ff[k] <= '0;
            else if (en_ff) acc_ff[k] <= sat_add(acc_ff[k], prod_ff[k]);
         end
      end
   end
   assign acc = acc_ff;
endmodule

@@ rtl/core/sh9_merge.sv @@
// Merge stage: walks the 27 snapshot values, scales by gain, rounds and saturates.
module sh9_merge (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] gain,
   input  sh9_pkg::acc_type snap [27],
   sh9_stream_if.source rsp
);
   import sh9_pkg::*;
   logic [4:0] idx_ff;
   logic run_ff;
   logic [1:0] ch_ff;
   logic [3:0] k_ff;
   // stage A: magnitude split products
   logic a_valid_ff, a_neg_ff, a_last_ff;
   logic [1:0] a_ch_ff;
   logic [3:0] a_k_ff;
   logic [63:0] hi_ff, lo_ff;
   logic out_valid_ff;
   rsp_type out_ff;
   logic adv;
   acc_type v;
   logic neg;
   logic [63:0] m;
   logic [63:0] q, sum;
   logic [47:0] res;

   assign adv = !out_valid_ff || rsp.ready;

   always_comb begin
      v = snap[idx_ff];
      neg = v[63];
      m = neg ? 64'd0 - 64'(v) : 64'(v);
      sum = (hi_ff << 18) + ((lo_ff + 64'd8192) >> 14);
      q = (hi_ff >= (64'd1 << 30)) ? 64'(OUT_NEG_MAG) : sum;
      if (a_neg_ff) begin
         if (q > 64'(OUT_NEG_MAG)) q = 64'(OUT_NEG_MAG);
         res = 48'(64'd0 - q);
      end else begin
         if (q > 64'(OUT_POS_MAX)) q = 64'(OUT_POS_MAX);
         res = q[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
         ch_ff <= '0;
         k_ff <= '0;
      end else begin
         if (start) begin
            run_ff <= 1'b1;
            idx_ff <= '0;
            ch_ff <= '0;
            k_ff <= '0;
         end else if (adv) begin
            if (run_ff) begin
               if (idx_ff == 5'(NUM_ACC - 1)) run_ff <= 1'b0;
               idx_ff <= idx_ff + 5'd1;
               if (k_ff == 4'(NUM_BASIS - 1)) begin
                  k_ff <= '0;
                  ch_ff <= ch_ff + 2'd1;
               end else k_ff <= k_ff + 4'd1;
            end
            a_valid_ff <= run_ff;
            out_valid_ff <= a_valid_ff;
         end
      end
      if (adv) begin
         hi_ff <= (m >> 32) * {32'd0, gain};
         lo_ff <= {32'd0, m[31:0]} * {32'd0, gain};
         a_neg_ff <= neg;
         a_ch_ff <= ch_ff;
         a_k_ff <= k_ff;
         a_last_ff <= idx_ff == 5'(NUM_ACC - 1);
         out_ff.channel <= a_ch_ff;
         out_ff.coeff_index <= a_k_ff;
         out_ff.coeff_value <= res;
         out_ff.last_coeff <= a_last_ff;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule

@@ rtl/core/sh9_irradiance_projection.sv @@
// Top level: SH order-2 projection of an HDR lat-long map, three color lanes.
// Usage:
//  req channel: one pixel transaction (RGB Q8.8, direction Q1.14, sin weight,
//  last_pixel). Pixels are taken one per cycle while no emission is pending.
//  Each pixel passes a two-stage basis unit, then a product register, then
//  the saturating add into the 27 accumulators held in three lanes.
//  On a pixel with last_pixel set, once its add completes the 27 sums are
//  copied to a snapshot and cleared; the merge stage then emits 27 rsp
//  transactions (red, green, blue; basis 0..8), last_coeff on the 27th.
//  The first result follows the last pixel through the basis unit, product
//  register, add, snapshot, merge stage A and output register. Results go
//  out one per cycle while rsp is ready, set by the shared merge multiplier.
//  req_ready is low from acceptance of a last pixel until the final result
//  has been taken. A stall on rsp holds the output register and merge walk.
//  csr_write_enable/csr_write_data load the gain register (Q16.16); write only
//  when idle. Reset (synchronous) clears accumulators, gain returns to 1.0.
module sh9_irradiance_projection #(
   parameter logic [31:0] GainReset = sh9_pkg::GAIN_RESET
) (
   input  logic clock,
   input  logic reset,
   sh9_stream_if.sink req,
   sh9_stream_if.source rsp,
   input  logic csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import sh9_pkg::*;
   logic [31:0] gain_ff;
   logic hold_ff;
   logic accept;
   logic b_valid, b_last;
   basis_type basis [9];
   logic [16:0] rw [3];
   acc_type acc [3][9];
   acc_type snap_ff [27];
   logic [1:0] last_pipe_ff;
   logic clear, start;

   assign req.ready = !hold_ff;
   assign accept = req.valid && req.ready;

   sh9_basis u_basis (
      .clock(clock), .reset(reset), .in_valid(accept), .in_item(req.payload),
      .out_valid(b_valid), .out_basis(basis), .out_rw(rw), .out_last(b_last)
   );

   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      sh9_lane u_lane (
         .clock(clock), .reset(reset), .acc_en(b_valid), .clear(clear),
         .rw(rw[g]), .basis(basis), .acc(acc[g])
      );
   end

   // last flag follows the product register, then the add
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pipe_ff <= '0;
         hold_ff <= 1'b0;
         gain_ff <= GainReset;
      end else begin
         last_pipe_ff <= {last_pipe_ff[0], b_valid && b_last};
         if (csr_write_enable) gain_ff <= csr_write_data;
         // input stays closed until the 27th coefficient is taken
         if (accept && req.payload.last_pixel) hold_ff <= 1'b1;
         else if (rsp.valid && rsp.ready && rsp.payload.last_coeff)
            hold_ff <= 1'b0;
      end
   end

   // clear happens the cycle after the last add has landed
   assign clear = last_pipe_ff[1];
   assign start = clear;

   always_ff @(posedge clock) begin
      if (clear)
         for (int c = 0; c < NUM_CH; c++)
            for (int k = 0; k < NUM_BASIS; k++)
               snap_ff[c * NUM_BASIS + k] <= acc[c][k];
   end

   sh9_merge u_merge (
      .clock(clock), .reset(reset), .start(start), .gain(gain_ff),
      .snap(snap_ff), .rsp(rsp)
   );
endmodule

@@ rtl/core/sh9_checker.sv @@
// Checker: port-level properties of the SH9 projection, bound to the top level.
module sh9_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_channel,
   input logic [3:0] rsp_index,
   input logic rsp_last
);
   a_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel != 2'd3 && rsp_index < 4'd9) else $error("bad code");
   a_lastpos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_channel == 2'd2 && rsp_index == 4'd8)
      else $error("last misplaced");
   a_block: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready) else $error("no hold");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input open during emission");
endmodule

bind sh9_irradiance_projection sh9_checker u_sh9_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_last(req.payload.last_pixel),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_channel(rsp.payload.channel), .rsp_index(rsp.payload.coeff_index),
   .rsp_last(rsp.payload.last_coeff)
);
